[rtl/cpg_pkg.sv]
// ----------------------------------------------------------------------------
// cpg_pkg
// Types and constants shared by the circle pixel generator modules.
// ----------------------------------------------------------------------------
package cpg_pkg;

    // command action codes
    localparam logic ACT_START = 1'b0;
    localparam logic ACT_STEP  = 1'b1;

    // configuration register indexes
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    // configuration reset values
    localparam logic [15:0] WIDTH_RESET  = 16'd480;
    localparam logic [15:0] HEIGHT_RESET = 16'd320;

    // decision term constants
    localparam logic signed [23:0] DEC_INIT    = 24'sd3;
    localparam logic signed [23:0] DEC_NEG_ADD = 24'sd6;
    localparam logic signed [23:0] DEC_POS_ADD = 24'sd10;

    // rgb565 channel masks for the left-aligned colour bytes
    localparam logic [7:0] RED_MASK   = 8'hF8;
    localparam logic [7:0] GREEN_MASK = 8'hFC;

    // pixel slots in one step
    localparam int          NUM_SLOTS  = 10;
    localparam logic [3:0]  LAST_SLOT  = 4'(NUM_SLOTS - 1);
    localparam logic [3:0]  FIRST_SLOT = 4'd0;

    // offset codes applied to a centre coordinate
    localparam logic [1:0] OFS_SUB_A = 2'd0;
    localparam logic [1:0] OFS_ADD_A = 2'd1;
    localparam logic [1:0] OFS_SUB_B = 2'd2;
    localparam logic [1:0] OFS_ADD_B = 2'd3;

    // per-slot offsets; the last slot uses the updated a and b
    localparam logic [1:0] X_SEL [0:NUM_SLOTS-1] = '{
        OFS_SUB_B, OFS_ADD_B, OFS_SUB_A, OFS_SUB_B, OFS_SUB_A,
        OFS_ADD_B, OFS_ADD_A, OFS_ADD_A, OFS_SUB_B, OFS_ADD_A
    };
    localparam logic [1:0] Y_SEL [0:NUM_SLOTS-1] = '{
        OFS_SUB_A, OFS_SUB_A, OFS_ADD_B, OFS_SUB_A, OFS_SUB_B,
        OFS_ADD_A, OFS_SUB_B, OFS_ADD_B, OFS_ADD_A, OFS_ADD_B
    };

    // snapshot of one step handed from the core to the emitter
    typedef struct packed {
        logic        done;
        logic [15:0] cx;
        logic [15:0] cy;
        logic [15:0] colour;
        logic [15:0] a;
        logic [15:0] b;
        logic [15:0] a_nx;
        logic [15:0] b_nx;
    } t_burst;

    // visible screen area
    typedef struct packed {
        logic [15:0] width;
        logic [15:0] height;
    } t_screen;

endpackage

[rtl/cpg_cmd_if.sv]
// ----------------------------------------------------------------------------
// cpg_cmd_if
// Command channel: start or step transactions with circle parameters.
// ----------------------------------------------------------------------------
interface cpg_cmd_if;
    logic        valid;
    logic        ready;
    logic        action;
    logic [15:0] center_x;
    logic [15:0] center_y;
    logic [15:0] radius;
    logic [15:0] colour;

    modport source (output valid, action, center_x, center_y, radius, colour,
                    input ready);
    modport sink (input valid, action, center_x, center_y, radius, colour,
                  output ready);
endinterface

[rtl/cpg_pix_if.sv]
// ----------------------------------------------------------------------------
// cpg_pix_if
// Pixel channel: one pixel write or done marker per transaction.
// ----------------------------------------------------------------------------
interface cpg_pix_if;
    logic        valid;
    logic        ready;
    logic [15:0] pixel_x;
    logic [15:0] pixel_y;
    logic [7:0]  red_byte;
    logic [7:0]  green_byte;
    logic [7:0]  blue_byte;
    logic        visible;
    logic        last;
    logic        done_res;

    modport source (output valid, pixel_x, pixel_y, red_byte, green_byte,
                    blue_byte, visible, last, done_res, input ready);
    modport sink (input valid, pixel_x, pixel_y, red_byte, green_byte,
                  blue_byte, visible, last, done_res, output ready);
endinterface

[rtl/cpg_core.sv]
// ----------------------------------------------------------------------------
// cpg_core
// Circle state and midpoint update; hands a snapshot of each step onward.
// ----------------------------------------------------------------------------
module cpg_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  logic               i_action,
    input  logic [15:0]        i_center_x,
    input  logic [15:0]        i_center_y,
    input  logic [15:0]        i_radius,
    input  logic [15:0]        i_colour,
    input  logic               i_cfg_we,
    input  logic               i_cfg_idx,
    input  logic [15:0]        i_cfg_data,
    output cpg_pkg::t_burst    o_burst,
    output cpg_pkg::t_screen   o_screen
);

    logic [15:0]        r_cx, r_cy, r_col;
    logic signed [16:0] r_a, r_b;
    logic signed [23:0] r_dec;
    logic               r_run;
    logic [15:0]        r_width, r_height;

    logic               pass;
    logic signed [16:0] a_nx, b_nx;
    logic signed [23:0] n_dec, dec_start;
    logic               n_run;

    // midpoint update for one pass
    always_comb begin
        pass = r_run && !(r_a > r_b);
        a_nx = r_a + 17'sd1;
        if (r_dec[23]) begin
            n_dec = r_dec + (24'(a_nx) <<< 2) + cpg_pkg::DEC_NEG_ADD;
            b_nx  = r_b;
        end else begin
            n_dec = r_dec + cpg_pkg::DEC_POS_ADD + (24'(a_nx - r_b) <<< 2);
            b_nx  = r_b - 17'sd1;
        end
        n_run     = !(a_nx > b_nx);
        dec_start = cpg_pkg::DEC_INIT - $signed(24'(i_radius) << 1);
    end

    // circle state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cx  <= '0;
            r_cy  <= '0;
            r_col <= '0;
            r_a   <= '0;
            r_b   <= '0;
            r_dec <= '0;
            r_run <= 1'b0;
        end else if (i_accept) begin
            if (i_action == cpg_pkg::ACT_START) begin
                r_cx  <= i_center_x;
                r_cy  <= i_center_y;
                r_col <= i_colour;
                r_a   <= '0;
                r_b   <= $signed({1'b0, i_radius});
                r_dec <= dec_start;
                r_run <= 1'b1;
            end else if (pass) begin
                r_a   <= a_nx;
                r_b   <= b_nx;
                r_dec <= n_dec;
                r_run <= n_run;
            end else begin
                r_run <= 1'b0;
            end
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= cpg_pkg::WIDTH_RESET;
            r_height <= cpg_pkg::HEIGHT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                cpg_pkg::REG_WIDTH:  r_width  <= i_cfg_data;
                cpg_pkg::REG_HEIGHT: r_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // step snapshot
    always_comb begin
        o_burst.done   = !pass;
        o_burst.cx     = r_cx;
        o_burst.cy     = r_cy;
        o_burst.colour = r_col;
        o_burst.a      = r_a[15:0];
        o_burst.b      = r_b[15:0];
        o_burst.a_nx   = a_nx[15:0];
        o_burst.b_nx   = b_nx[15:0];
        o_screen.width  = r_width;
        o_screen.height = r_height;
    end

endmodule

[rtl/cpg_emitter.sv]
// ----------------------------------------------------------------------------
// cpg_emitter
// Walks the pixel slots of a step snapshot into the output register.
// ----------------------------------------------------------------------------
module cpg_emitter (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  cpg_pkg::t_burst    i_burst,
    input  cpg_pkg::t_screen   i_screen,
    output logic               o_cmd_ready,
    cpg_pix_if.source          o_pix
);

    cpg_pkg::t_burst r_burst;
    logic            r_busy;
    logic [3:0]      r_idx;

    logic            r_out_valid;
    logic [15:0]     r_out_x, r_out_y;
    logic [7:0]      r_out_red, r_out_green, r_out_blue;
    logic            r_out_vis, r_out_last, r_out_done;

    logic            adv, at_end;
    logic [15:0]     sa, sb;
    logic [15:0]     n_x, n_y;
    logic [7:0]      n_red, n_green, n_blue;
    logic            n_vis, n_last;

    function automatic logic [15:0] offset(input logic [15:0] base,
                                           input logic [15:0] a,
                                           input logic [15:0] b,
                                           input logic [1:0]  code);
        logic [15:0] res;
        res = base;
        case (code)
            cpg_pkg::OFS_SUB_A: res = base - a;
            cpg_pkg::OFS_ADD_A: res = base + a;
            cpg_pkg::OFS_SUB_B: res = base - b;
            cpg_pkg::OFS_ADD_B: res = base + b;
            default:            res = base;
        endcase
        return res;
    endfunction

    // slot sequencing
    always_comb begin
        adv    = r_busy && (!r_out_valid || o_pix.ready);
        at_end = r_burst.done || (r_idx == cpg_pkg::LAST_SLOT);
        o_cmd_ready = !r_busy || (adv && at_end);
    end

    // pixel for the current slot
    always_comb begin
        if (r_idx == cpg_pkg::LAST_SLOT) begin
            sa = r_burst.a_nx;
            sb = r_burst.b_nx;
        end else begin
            sa = r_burst.a;
            sb = r_burst.b;
        end
        n_x     = offset(r_burst.cx, sa, sb, cpg_pkg::X_SEL[r_idx]);
        n_y     = offset(r_burst.cy, sa, sb, cpg_pkg::Y_SEL[r_idx]);
        n_red   = 8'(r_burst.colour >> 8) & cpg_pkg::RED_MASK;
        n_green = 8'(r_burst.colour >> 3) & cpg_pkg::GREEN_MASK;
        n_blue  = 8'(r_burst.colour << 3);
        n_vis   = (n_x < i_screen.width) && (n_y < i_screen.height);
        n_last  = (r_idx == cpg_pkg::LAST_SLOT);
    end

    // snapshot register and slot counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= cpg_pkg::FIRST_SLOT;
        end else begin
            if (adv) begin
                if (at_end) begin
                    r_busy <= 1'b0;
                    r_idx  <= cpg_pkg::FIRST_SLOT;
                end else begin
                    r_idx <= r_idx + 4'd1;
                end
            end
            if (i_load) begin
                r_busy <= 1'b1;
                r_idx  <= cpg_pkg::FIRST_SLOT;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_burst <= i_burst;
        end
    end

    // output register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (o_pix.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (adv) begin
            if (r_burst.done) begin
                r_out_x     <= '0;
                r_out_y     <= '0;
                r_out_red   <= '0;
                r_out_green <= '0;
                r_out_blue  <= '0;
                r_out_vis   <= 1'b0;
                r_out_last  <= 1'b1;
                r_out_done  <= 1'b1;
            end else begin
                r_out_x     <= n_x;
                r_out_y     <= n_y;
                r_out_red   <= n_red;
                r_out_green <= n_green;
                r_out_blue  <= n_blue;
                r_out_vis   <= n_vis;
                r_out_last  <= n_last;
                r_out_done  <= 1'b0;
            end
        end
    end

    assign o_pix.valid      = r_out_valid;
    assign o_pix.pixel_x    = r_out_x;
    assign o_pix.pixel_y    = r_out_y;
    assign o_pix.red_byte   = r_out_red;
    assign o_pix.green_byte = r_out_green;
    assign o_pix.blue_byte  = r_out_blue;
    assign o_pix.visible    = r_out_vis;
    assign o_pix.last       = r_out_last;
    assign o_pix.done_res   = r_out_done;

endmodule

[rtl/circle_pixel_generator_top.sv]
// ----------------------------------------------------------------------------
// circle_pixel_generator_top
// Midpoint circle pixel generator with screen clipping and rgb565 byte output.
// ----------------------------------------------------------------------------
// Usage:
//   i_cmd carries start and step transactions. A start loads centre, radius
//   and colour and gives no pixel transaction. A step runs one pass of the
//   circle loop and gives ten pixel transactions on o_pix, the tenth with
//   last set; once the circle is finished a step gives a single transaction
//   with done_res and last set.
//   A step is captured in the snapshot register before its first pixel
//   enters the output register. Throughput: one pixel per cycle while
//   o_pix.ready is high; the slot counter in the emitter walks the ten
//   pixels and i_cmd.ready rises again as the final pixel enters the output
//   register. Starts are accepted whenever i_cmd.ready is high. Reset:
//   output register empty, circle idle, width 480, height 320. Stall: a low
//   o_pix.ready holds the output register and the slot counter; i_cmd.ready
//   stays low until the step's last pixel moves in. Configuration writes
//   on i_cfg_we take effect the next cycle; the user must make them while
//   no transactions are in flight, which the block does not enforce.
// ----------------------------------------------------------------------------
module circle_pixel_generator_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    cpg_cmd_if.sink     i_cmd,
    cpg_pix_if.source   o_pix,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [15:0] i_cfg_data
);

    cpg_pkg::t_burst  burst;
    cpg_pkg::t_screen screen;
    logic             accept;
    logic             load;
    logic             cmd_ready;

    // command handshake
    assign i_cmd.ready = cmd_ready;
    assign accept      = i_cmd.valid && cmd_ready;
    assign load        = accept && (i_cmd.action == cpg_pkg::ACT_STEP);

    // circle state
    cpg_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_action   (i_cmd.action),
        .i_center_x (i_cmd.center_x),
        .i_center_y (i_cmd.center_y),
        .i_radius   (i_cmd.radius),
        .i_colour   (i_cmd.colour),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_burst    (burst),
        .o_screen   (screen)
    );

    // pixel sequencing
    cpg_emitter u_emitter (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (load),
        .i_burst     (burst),
        .i_screen    (screen),
        .o_cmd_ready (cmd_ready),
        .o_pix       (o_pix)
    );

endmodule

[rtl/cpg_checker.sv]
// ----------------------------------------------------------------------------
// cpg_checker
// Port-level checks of the circle pixel generator, bound to the top level.
// ----------------------------------------------------------------------------
module cpg_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_cmd_ready,
    input logic        i_pix_valid,
    input logic        i_pix_ready,
    input logic [15:0] i_pix_x,
    input logic        i_pix_visible,
    input logic        i_pix_last,
    input logic        i_pix_done
);

    // output register is empty after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_pix_valid)
        else $error("pixel valid after reset");

    // a stalled pixel transaction holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pix_valid && !i_pix_ready |=> i_pix_valid && $stable(i_pix_x))
        else $error("stalled pixel transaction changed");

    // done marker is always a lone final transaction with a blank pixel
    a_done_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pix_valid && i_pix_done |-> i_pix_last && !i_pix_visible &&
        (i_pix_x == 16'd0))
        else $error("malformed done transaction");

    // no new command while a step still has pixels pending behind a stall
    a_busy_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pix_valid && !i_pix_last && !i_pix_ready |-> !i_cmd_ready)
        else $error("command ready while step pixels pending");

endmodule

bind circle_pixel_generator_top cpg_checker u_cpg_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_cmd_ready   (i_cmd.ready),
    .i_pix_valid   (o_pix.valid),
    .i_pix_ready   (o_pix.ready),
    .i_pix_x       (o_pix.pixel_x),
    .i_pix_visible (o_pix.visible),
    .i_pix_last    (o_pix.last),
    .i_pix_done    (o_pix.done_res)
);
